// ===== design/thd_pkg.sv =====
// shared types, constants and the crc-8 step for the sensor frame decoder
// no dependencies; imported by the interfaces and every module of the block
package thd_pkg;

	localparam int unsigned SCALE = 1;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam int unsigned RAW_W = 16;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned HUM_W = 14;

	// 175 * 100 per degree, 1000 per humidity range, both over full scale 65535
	localparam int unsigned T_GAIN = 17500 * SCALE;
	localparam int unsigned H_GAIN = 1000 * SCALE;
	localparam int unsigned T_OFFSET = 4500 * SCALE;
	localparam int unsigned GAIN_W = $clog2(T_GAIN + 1);
	localparam int unsigned PROD_W = RAW_W + GAIN_W;
	localparam int unsigned Q_W = PROD_W - 16;
	localparam int unsigned HUM_MAX = H_GAIN;

	typedef enum logic [5:0] {
		POS_T_HI  = 6'b000001,
		POS_T_LO  = 6'b000010,
		POS_T_CRC = 6'b000100,
		POS_H_HI  = 6'b001000,
		POS_H_LO  = 6'b010000,
		POS_H_CRC = 6'b100000
	} pos_t;

	// msb-first crc-8, one byte
	function automatic logic [7:0] crc8_feed(input logic [7:0] rem, input logic [7:0] b);
		logic [7:0] r;
		r = rem ^ b;
		for (int i = 0; i < 8; i++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

// ===== design/thd_if.sv =====
// byte request and result channels of the sensor frame decoder
// depends on thd_pkg for field widths
interface thd_in_if;
	import thd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       frame_start;

	modport source(output valid, byte_value, frame_start, input ready);
	modport sink(input valid, byte_value, frame_start, output ready);
endinterface

interface thd_out_if;
	import thd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [TEMP_W-1:0] temperature;
	logic [HUM_W-1:0]         humidity;

	modport source(output valid, status, temperature, humidity, input ready);
	modport sink(input valid, status, temperature, humidity, output ready);
endinterface

// ===== design/thd_convert.sv =====
// scales raw temperature and humidity words to fixed point, divide by 65535 included
// depends on thd_pkg
module thd_convert (
	input  logic [thd_pkg::RAW_W-1:0]         raw_temperature,
	input  logic [thd_pkg::RAW_W-1:0]         raw_humidity,
	output logic signed [thd_pkg::TEMP_W-1:0] temperature,
	output logic [thd_pkg::HUM_W-1:0]         humidity
);
	import thd_pkg::*;

	localparam int unsigned C_W = ((Q_W > 16) ? Q_W : 16) + 1;

	// x = a*65536 + b = a*65535 + (a + b); fold the carry term twice, then one compare
	function automatic logic [Q_W-1:0] div_65535(input logic [PROD_W-1:0] x);
		logic [Q_W-1:0]    a;
		logic [C_W-1:0]    c;
		logic [C_W-17:0]   a2;
		logic [16:0]       d;
		a  = x[PROD_W-1:16];
		c  = C_W'(a) + C_W'(x[15:0]);
		a2 = c[C_W-1:16];
		d  = 17'(a2) + 17'(c[15:0]);
		return a + Q_W'(a2) + Q_W'(d >= 17'd65535);
	endfunction

	logic [PROD_W-1:0] t_prod;
	logic [PROD_W-1:0] h_prod;
	logic [Q_W-1:0]    t_quot;
	logic [Q_W-1:0]    h_quot;

	assign t_prod = PROD_W'(raw_temperature) * PROD_W'(T_GAIN);
	assign h_prod = PROD_W'(raw_humidity) * PROD_W'(H_GAIN);
	assign t_quot = div_65535(t_prod);
	assign h_quot = div_65535(h_prod);

	assign temperature = $signed(TEMP_W'(t_quot) - TEMP_W'(T_OFFSET));
	assign humidity    = HUM_W'(h_quot);

endmodule

// ===== design/temp_humidity_frame_decoder.sv =====
// temperature and humidity sensor frame decoder: six bytes in, one checked and scaled result out
// the result becomes valid in the cycle after the sixth byte (humidity crc) is accepted
// one byte per cycle unless a result waits untaken; the output register holds it until taken
// reset: byte position returns to the first byte, crc to 0xff, no result pending
// depends on thd_pkg, thd_if and thd_convert
module temp_humidity_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	thd_in_if.sink     rx,
	thd_out_if.source  result
);
	import thd_pkg::*;

	pos_t             pos_q;
	pos_t             pos_cur;
	pos_t             pos_nxt;
	logic [7:0]       crc_q;
	logic [7:0]       crc_nxt;
	logic [RAW_W-1:0] raw_t_q;
	logic [RAW_W-1:0] raw_t_nxt;
	logic [RAW_W-1:0] raw_h_q;
	logic [RAW_W-1:0] raw_h_nxt;
	logic             fail_q;
	logic             fail_nxt;
	logic             rx_acc;
	logic             last_byte;
	logic             bad;

	logic                     out_valid_q;
	logic                     status_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [HUM_W-1:0]         hum_q;
	logic signed [TEMP_W-1:0] temp_calc;
	logic [HUM_W-1:0]         hum_calc;

	assign rx.ready = !out_valid_q || result.ready;
	assign rx_acc   = rx.valid && rx.ready;
	assign pos_cur  = rx.frame_start ? POS_T_HI : pos_q;
	assign last_byte = (pos_cur == POS_H_CRC);
	assign bad = fail_q || (crc_q != rx.byte_value);

	always_comb begin
		pos_nxt   = POS_T_HI;
		crc_nxt   = crc_q;
		raw_t_nxt = raw_t_q;
		raw_h_nxt = raw_h_q;
		fail_nxt  = rx.frame_start ? 1'b0 : fail_q;
		case (pos_cur)
			POS_T_LO: begin
				crc_nxt   = crc8_feed(crc_q, rx.byte_value);
				raw_t_nxt = {raw_t_q[15:8], rx.byte_value};
				pos_nxt   = POS_T_CRC;
			end
			POS_T_CRC: begin
				if (crc_q != rx.byte_value) begin
					fail_nxt = 1'b1;
				end
				crc_nxt = CRC_INIT;
				pos_nxt = POS_H_HI;
			end
			POS_H_HI: begin
				crc_nxt   = crc8_feed(CRC_INIT, rx.byte_value);
				raw_h_nxt = {rx.byte_value, 8'h00};
				pos_nxt   = POS_H_LO;
			end
			POS_H_LO: begin
				crc_nxt   = crc8_feed(crc_q, rx.byte_value);
				raw_h_nxt = {raw_h_q[15:8], rx.byte_value};
				pos_nxt   = POS_H_CRC;
			end
			POS_H_CRC: begin
				crc_nxt  = CRC_INIT;
				fail_nxt = 1'b0;
				pos_nxt  = POS_T_HI;
			end
			default: begin
				// first byte of a frame, also any unexpected position code
				fail_nxt  = 1'b0;
				crc_nxt   = crc8_feed(CRC_INIT, rx.byte_value);
				raw_t_nxt = {rx.byte_value, 8'h00};
				pos_nxt   = POS_T_LO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_T_HI;
			crc_q   <= CRC_INIT;
			raw_t_q <= '0;
			raw_h_q <= '0;
			fail_q  <= 1'b0;
		end else if (rx_acc) begin
			pos_q   <= pos_nxt;
			crc_q   <= crc_nxt;
			raw_t_q <= raw_t_nxt;
			raw_h_q <= raw_h_nxt;
			fail_q  <= fail_nxt;
		end
	end

	thd_convert u_convert (
		.raw_temperature(raw_t_q),
		.raw_humidity   (raw_h_q),
		.temperature    (temp_calc),
		.humidity       (hum_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_acc && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// crc mismatch zeroes both values
	always_ff @(posedge clk) begin
		if (rx_acc && last_byte) begin
			status_q <= bad;
			temp_q   <= bad ? '0 : temp_calc;
			hum_q    <= bad ? '0 : hum_calc;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = status_q;
	assign result.temperature = temp_q;
	assign result.humidity    = hum_q;

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && last_byte) |=> result.valid)
		else $error("final byte accepted but no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!result.valid && !(rx_acc && last_byte)) |=> !result.valid)
		else $error("result appeared without a final byte");

	a_bad_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |-> (result.temperature == '0 && result.humidity == '0))
		else $error("failed frame carries nonzero values");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.humidity <= HUM_W'(HUM_MAX)))
		else $error("humidity above full scale");

endmodule
